@@ rtl/esd_pkg.sv @@
// esd_pkg: shared types, character codes and hex digit decode
// for the escape sequence decoder; no dependencies
`timescale 1ns / 1ps

package esd_pkg;

    // default byte limit per string and fixed result count width
    localparam int MAX_LEN_DEF = 4096;
    localparam int OUT_COUNT_W = 13;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    // decoded escape bytes
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX1 = 2'd2,
        MODE_HEX2 = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    // decoder state apart from the byte counter
    typedef struct packed {
        t_mode      mode;
        logic [3:0] nibble;
        logic       failed;
    } t_dec_state;

    // one result item apart from the count
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // hex digit to nibble, ok low for a non-hex character
    function automatic t_hex hex_value(input logic [7:0] ch);
        t_hex h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            h.nib = 4'(ch - CH_ZERO);
        end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
            h.nib = 4'(ch - CH_LC_A + 8'd10);
        end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
            h.nib = 4'(ch - CH_UC_A + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ rtl/escape_sequence_decoder_core.sv @@
// Output: the result of each input transfer is registered on the output register.
// Throughput: one character per cycle; a new character is taken while the previous
// result is presented, and only a stalled full output register holds the input.
// Reset: i_rst_n synchronous active low; clears decoder state and the output valid.
// escape_sequence_decoder_core: top level; depends on esd_pkg and esd_step
`timescale 1ns / 1ps

module escape_sequence_decoder_core #(
    parameter int MAX_LEN = esd_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [esd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_in
    input  logic                          s_axis_tlast,  // is_final
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [9:8] status, [22:10] out_count, [23] zero
    output logic [esd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser   // byte_valid
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    esd_pkg::t_dec_state r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    esd_pkg::t_result    r_out, n_out;
    logic [CNT_W-1:0]    r_out_count, n_out_count;
    logic                w_in_xfer;
    logic [31:0]         w_count_ext;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    esd_step #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_step (
        .i_char      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_state     (r_state),
        .i_count     (r_count),
        .o_state     (n_state),
        .o_count     (n_count),
        .o_res_count (n_out_count),
        .o_res       (n_out)
    );

    // decoder state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode   <= esd_pkg::MODE_TEXT;
            r_state.nibble <= 4'd0;
            r_state.failed <= 1'b0;
            r_count        <= '0;
        end else if (w_in_xfer) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out       <= n_out;
            r_out_count <= n_out_count;
        end
    end

    assign w_count_ext   = 32'(r_out_count);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.byte_valid;
    assign m_axis_tdata  = {1'b0, w_count_ext[esd_pkg::OUT_COUNT_W-1:0],
                            r_out.status, r_out.out_byte};

endmodule

@@ rtl/esd_step.sv @@
// esd_step: next state and result for one accepted character
// depends on esd_pkg
`timescale 1ns / 1ps

module esd_step #(
    parameter int MAX_LEN = esd_pkg::MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  logic [7:0]          i_char,
    input  logic                i_last,
    input  esd_pkg::t_dec_state i_state,
    input  logic [CNT_W-1:0]    i_count,
    output esd_pkg::t_dec_state o_state,
    output logic [CNT_W-1:0]    o_count,
    output logic [CNT_W-1:0]    o_res_count,
    output esd_pkg::t_result    o_res
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LEN);

    esd_pkg::t_dec_state w_st;
    esd_pkg::t_hex       w_hex;
    logic                w_have;
    logic [7:0]          w_value;
    logic [CNT_W-1:0]    w_count;

    assign w_hex = esd_pkg::hex_value(i_char);

    // escape decode, byte limit and end-of-string check
    always_comb begin
        w_st    = i_state;
        w_have  = 1'b0;
        w_value = 8'd0;
        w_count = i_count;
        if (!i_state.failed) begin
            unique case (i_state.mode)
                esd_pkg::MODE_TEXT: begin
                    if (i_char == esd_pkg::CH_BSLASH) begin
                        w_st.mode = esd_pkg::MODE_ESC;
                    end else begin
                        w_have  = 1'b1;
                        w_value = i_char;
                    end
                end
                esd_pkg::MODE_ESC: begin
                    w_st.mode = esd_pkg::MODE_TEXT;
                    priority if (i_char == esd_pkg::CH_ZERO) begin
                        w_have = 1'b1; w_value = esd_pkg::BYTE_NUL;
                    end else if (i_char == esd_pkg::CH_R) begin
                        w_have = 1'b1; w_value = esd_pkg::BYTE_CR;
                    end else if (i_char == esd_pkg::CH_T) begin
                        w_have = 1'b1; w_value = esd_pkg::BYTE_TAB;
                    end else if (i_char == esd_pkg::CH_N) begin
                        w_have = 1'b1; w_value = esd_pkg::BYTE_LF;
                    end else if (i_char == esd_pkg::CH_BSLASH) begin
                        w_have = 1'b1; w_value = esd_pkg::CH_BSLASH;
                    end else if (i_char == esd_pkg::CH_X) begin
                        w_st.mode = esd_pkg::MODE_HEX1;
                    end else begin
                        w_st.failed = 1'b1;
                    end
                end
                esd_pkg::MODE_HEX1: begin
                    if (!w_hex.ok) begin
                        w_st.failed = 1'b1;
                        w_st.mode   = esd_pkg::MODE_TEXT;
                    end else begin
                        w_st.nibble = w_hex.nib;
                        w_st.mode   = esd_pkg::MODE_HEX2;
                    end
                end
                esd_pkg::MODE_HEX2: begin
                    w_st.mode = esd_pkg::MODE_TEXT;
                    if (!w_hex.ok) begin
                        w_st.failed = 1'b1;
                    end else begin
                        w_have  = 1'b1;
                        w_value = {i_state.nibble, w_hex.nib};
                    end
                end
                default: begin
                    w_st.mode = esd_pkg::MODE_TEXT;
                end
            endcase

            // count the byte or fail on overflow
            if (w_have) begin
                if (i_count >= LIMIT) begin
                    w_st.failed = 1'b1;
                    w_have      = 1'b0;
                end else begin
                    w_count = i_count + 1'b1;
                end
            end

            // string closed inside an escape
            if (i_last && w_st.mode != esd_pkg::MODE_TEXT) begin
                w_st.failed = 1'b1;
            end
        end
    end

    // result item
    always_comb begin
        o_res.byte_valid = w_have && !w_st.failed;
        o_res.out_byte   = o_res.byte_valid ? w_value : 8'd0;
        if (w_st.failed) begin
            o_res.status = esd_pkg::ST_FAIL;
        end else if (i_last) begin
            o_res.status = esd_pkg::ST_DONE;
        end else begin
            o_res.status = esd_pkg::ST_RUN;
        end
        o_res_count = w_count;
    end

    // the last character returns everything to the reset state
    always_comb begin
        if (i_last) begin
            o_state.mode   = esd_pkg::MODE_TEXT;
            o_state.nibble = 4'd0;
            o_state.failed = 1'b0;
            o_count        = '0;
        end else begin
            o_state = w_st;
            o_count = w_count;
        end
    end

endmodule

@@ rtl/esd_checker.sv @@
// esd_checker: port-level assertions for the escape sequence decoder
// depends on esd_pkg; bound to escape_sequence_decoder_core below
`timescale 1ns / 1ps

module esd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [esd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an empty output register never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // no byte means a zero byte field
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte field set without byte_valid");

    // a failed string delivers no byte
    a_fail_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] == esd_pkg::ST_FAIL |-> !m_axis_tuser)
        else $error("byte delivered with failed status");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/escape_sequence_decoder_core_tb.sv @@
// escape_sequence_decoder_core_tb: self-checking bench for the escape decoder stream core
// drives strings through the input stream and scores every output transfer against a
// behavioral decoder model; depends on esd_pkg and escape_sequence_decoder_core
`timescale 1ns / 1ps

module escape_sequence_decoder_core_tb;

    localparam int STR_LIMIT = esd_pkg::MAX_LEN_DEF;

    // one expected output transfer
    typedef struct packed {
        logic [7:0]                      out_byte;
        logic                            byte_valid;
        esd_pkg::t_status                status;
        logic [esd_pkg::OUT_COUNT_W-1:0] out_count;
    } t_decoded;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [esd_pkg::S_TDATA_W-1:0] s_axis_tdata;   // [7:0] char_in
    logic                          s_axis_tlast;   // is_final
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // [7:0] out_byte, [9:8] status, [22:10] out_count, [23] zero
    logic [esd_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tuser;   // byte_valid

    // decoder model state
    esd_pkg::t_mode dec_mode;
    logic [3:0]     dec_nibble;
    logic           dec_failed;
    int             dec_count;

    t_decoded    pending_results[$];
    logic [7:0]  str_chars[$];
    int          errors = 0;
    int          chars_sent = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    int          stall_mode = 0;
    int          rx_phase = 0;

    escape_sequence_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, well above the slowest legal run
    initial begin
        #5_000_000;
        $display("escape_sequence_decoder_core test failed");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_decoder();
        dec_mode   = esd_pkg::MODE_TEXT;
        dec_nibble = 4'd0;
        dec_failed = 1'b0;
        dec_count  = 0;
    endfunction

    // hex digit value, 16 for anything else
    function automatic int digit_val(input logic [7:0] ch);
        if (ch >= esd_pkg::CH_ZERO && ch <= esd_pkg::CH_NINE)
            return int'(ch) - int'(esd_pkg::CH_ZERO);
        if (ch >= esd_pkg::CH_LC_A && ch <= esd_pkg::CH_LC_F)
            return int'(ch) - int'(esd_pkg::CH_LC_A) + 10;
        if (ch >= esd_pkg::CH_UC_A && ch <= esd_pkg::CH_UC_F)
            return int'(ch) - int'(esd_pkg::CH_UC_A) + 10;
        return 16;
    endfunction

    // advance the model by one character and return the transfer it causes
    function automatic t_decoded decode_char(input logic [7:0] ch, input logic fin);
        t_decoded   r;
        logic       have;
        logic [7:0] value;
        int         nib;
        have  = 1'b0;
        value = 8'd0;
        if (!dec_failed) begin
            case (dec_mode)
                esd_pkg::MODE_TEXT: begin
                    if (ch == esd_pkg::CH_BSLASH) begin
                        dec_mode = esd_pkg::MODE_ESC;
                    end else begin
                        value = ch;
                        have  = 1'b1;
                    end
                end
                esd_pkg::MODE_ESC: begin
                    dec_mode = esd_pkg::MODE_TEXT;
                    have     = 1'b1;
                    case (ch)
                        esd_pkg::CH_ZERO:   value = esd_pkg::BYTE_NUL;
                        esd_pkg::CH_R:      value = esd_pkg::BYTE_CR;
                        esd_pkg::CH_T:      value = esd_pkg::BYTE_TAB;
                        esd_pkg::CH_N:      value = esd_pkg::BYTE_LF;
                        esd_pkg::CH_BSLASH: value = esd_pkg::CH_BSLASH;
                        esd_pkg::CH_X: begin
                            have     = 1'b0;
                            dec_mode = esd_pkg::MODE_HEX1;
                        end
                        default: begin
                            have       = 1'b0;
                            dec_failed = 1'b1;
                        end
                    endcase
                end
                esd_pkg::MODE_HEX1: begin
                    nib = digit_val(ch);
                    if (nib > 15) begin
                        dec_failed = 1'b1;
                        dec_mode   = esd_pkg::MODE_TEXT;
                    end else begin
                        dec_nibble = nib[3:0];
                        dec_mode   = esd_pkg::MODE_HEX2;
                    end
                end
                default: begin
                    nib      = digit_val(ch);
                    dec_mode = esd_pkg::MODE_TEXT;
                    if (nib > 15) begin
                        dec_failed = 1'b1;
                    end else begin
                        value = {dec_nibble, nib[3:0]};
                        have  = 1'b1;
                    end
                end
            endcase
            // byte limit per string
            if (have) begin
                if (dec_count >= STR_LIMIT) begin
                    dec_failed = 1'b1;
                    have       = 1'b0;
                end else begin
                    dec_count++;
                end
            end
            // string closed inside an escape
            if (fin && !dec_failed && dec_mode != esd_pkg::MODE_TEXT) dec_failed = 1'b1;
        end
        r.byte_valid = have && !dec_failed;
        r.out_byte   = r.byte_valid ? value : 8'd0;
        r.status     = dec_failed ? esd_pkg::ST_FAIL :
                       (fin ? esd_pkg::ST_DONE : esd_pkg::ST_RUN);
        r.out_count  = dec_count[esd_pkg::OUT_COUNT_W-1:0];
        if (fin) clear_decoder();
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic set_pace(input int gaps, input int stalls);
        gap_max    = gaps;
        stall_mode = stalls;
    endtask

    // one input transfer; called at a rising edge, returns at the accepting edge
    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(decode_char(ch, fin));
        chars_sent++;
    endtask

    // send the buffered string, final flag on its last character
    task automatic send_string();
        int n;
        n = str_chars.size();
        for (int i = 0; i < n; i++) send_char(str_chars[i], i == n - 1);
        str_chars.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) str_chars.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return esd_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) == 1) ? esd_pkg::CH_LC_A + 8'(v - 10)
                                           : esd_pkg::CH_UC_A + 8'(v - 10);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == esd_pkg::CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] bad_escape_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == esd_pkg::CH_ZERO || c == esd_pkg::CH_R || c == esd_pkg::CH_T ||
               c == esd_pkg::CH_N || c == esd_pkg::CH_BSLASH || c == esd_pkg::CH_X);
        return c;
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (digit_val(c) < 16);
        return c;
    endfunction

    // append one well-formed token: plain character, simple escape or hex escape
    task automatic push_token();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            str_chars.push_back(plain_char());
        end else if (kind < 7) begin
            str_chars.push_back(esd_pkg::CH_BSLASH);
            case ($urandom_range(0, 4))
                0: str_chars.push_back(esd_pkg::CH_ZERO);
                1: str_chars.push_back(esd_pkg::CH_R);
                2: str_chars.push_back(esd_pkg::CH_T);
                3: str_chars.push_back(esd_pkg::CH_N);
                default: str_chars.push_back(esd_pkg::CH_BSLASH);
            endcase
        end else begin
            str_chars.push_back(esd_pkg::CH_BSLASH);
            str_chars.push_back(esd_pkg::CH_X);
            str_chars.push_back(hex_char($urandom_range(0, 15)));
            str_chars.push_back(hex_char($urandom_range(0, 15)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_plain_text();
        str_chars.push_back(8'h00);
        str_chars.push_back(8'hFF);
        push_text("A");
        send_string();
    endtask

    task automatic test_simple_escapes();
        push_text("\\0\\r\\t\\n\\\\");
        send_string();
    endtask

    task automatic test_hex_escapes();
        push_text("\\xFF\\x0a");
        send_string();
    endtask

    task automatic test_malformed();
        // unknown escape, then characters that must be dropped
        push_text("\\qz");
        send_string();
        // bad high digit
        push_text("\\xga");
        send_string();
        // bad low digit
        push_text("\\x4Z");
        send_string();
        // string closed after the backslash, after x, after one digit
        push_text("\\");
        send_string();
        push_text("\\x");
        send_string();
        push_text("\\xA");
        send_string();
    endtask

    task automatic test_random_strings();
        int start;
        int n;
        start = chars_sent;
        while (chars_sent - start < 650) begin
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 3) == 0) set_pace(0, 0);
                else set_pace($urandom_range(1, 5), $urandom_range(1, 3));
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise with frequent backslashes
                n = $urandom_range(1, 20);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) str_chars.push_back(esd_pkg::CH_BSLASH);
                    else str_chars.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) push_token();
                if ($urandom_range(0, 6) == 0) begin
                    // broken sequence
                    str_chars.push_back(esd_pkg::CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0: str_chars.push_back(bad_escape_char());
                        1: begin
                            str_chars.push_back(esd_pkg::CH_X);
                            str_chars.push_back(bad_hex_char());
                        end
                        2: begin
                            str_chars.push_back(esd_pkg::CH_X);
                            str_chars.push_back(hex_char($urandom_range(0, 15)));
                            str_chars.push_back(bad_hex_char());
                        end
                        default: ;
                    endcase
                    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) push_token();
                end
            end
            send_string();
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // output stall pattern
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ((rx_phase % 7) > 2);
            default: m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // score each output transfer against the oldest expectation
    always @(posedge i_clk) begin : score_out
        t_decoded exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("out_byte", exp_r.out_byte, m_axis_tdata[7:0]);
                check_field("byte_valid", exp_r.byte_valid, m_axis_tuser);
                check_field("status", exp_r.status, m_axis_tdata[9:8]);
                check_field("out_count", exp_r.out_count, m_axis_tdata[22:10]);
                check_field("pad", 0, m_axis_tdata[23]);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        clear_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_pace(0, 0);
        test_plain_text();
        set_pace(3, 2);
        test_simple_escapes();
        test_hex_escapes();
        set_pace(2, 1);
        test_malformed();
        test_random_strings();

        // drain
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("escape_sequence_decoder_core test passed");
        end else begin
            $display("escape_sequence_decoder_core test failed");
        end
        $finish;
    end

endmodule
